### sv/grdfs_pkg.sv
// grdfs_pkg: shared types and constants for the graph reachability engine
// operation codes, field widths and the controller/datapath command and status structs
// no dependencies

package grdfs_pkg;

	localparam int KIND_W           = 2;
	localparam int VTX_W            = 6;
	localparam int CNT_W            = 7;
	localparam int MAX_VERTICES_DEF = 64;

	localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_WALK  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		logic load_op;
		logic adj_rd_src;
		logic adj_rd_stk;
		logic adj_wr;
		logic query_cap;
		logic mark_start;
		logic push_start;
		logic stk_pop;
		logic load_row;
		logic push_next;
		logic clear_marks;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  bad;
		logic  stack_empty;
		logic  pending_empty;
	} dp_status_t;

endpackage

### sv/grdfs_ram.sv
// grdfs_ram: generic simple dual-port RAM, one write port and one registered read port
// no dependencies

module grdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/grdfs_ctrl.sv
// grdfs_ctrl: sequencer for edge add/query, depth-first walk and mark clearing
// depends on grdfs_pkg; drives the datapath through dp_cmd_t and reads dp_status_t

module grdfs_ctrl
	import grdfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_WR,
		S_QUERY_RD,
		S_POP,
		S_POP_WAIT,
		S_ROW_WAIT,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_op = in_valid;
			end
			S_DECODE: begin
				if (!status.bad) begin
					case (status.kind)
						KIND_ADD:   cmd.adj_rd_src = 1'b1;
						KIND_QUERY: cmd.adj_rd_src = 1'b1;
						KIND_WALK: begin
							cmd.mark_start = 1'b1;
							cmd.push_start = 1'b1;
						end
						KIND_CLEAR: cmd.clear_marks = 1'b1;
						default:    cmd.clear_marks = 1'b0;
					endcase
				end
			end
			S_ADD_WR:   cmd.adj_wr    = 1'b1;
			S_QUERY_RD: cmd.query_cap = 1'b1;
			S_POP:      cmd.stk_pop   = !status.stack_empty;
			S_POP_WAIT: cmd.adj_rd_stk = 1'b1;
			S_ROW_WAIT: cmd.load_row  = 1'b1;
			S_SCAN:     cmd.push_next = !status.pending_empty;
			S_FINISH:   cmd.out_load  = !out_valid_q || !out_stall;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (status.bad) begin
						state_q <= S_FINISH;
					end else begin
						case (status.kind)
							KIND_ADD:   state_q <= S_ADD_WR;
							KIND_QUERY: state_q <= S_QUERY_RD;
							KIND_WALK:  state_q <= S_POP;
							default:    state_q <= S_FINISH;
						endcase
					end
				end
				S_ADD_WR:   state_q <= S_FINISH;
				S_QUERY_RD: state_q <= S_FINISH;
				S_POP: begin
					state_q <= status.stack_empty ? S_FINISH : S_POP_WAIT;
				end
				S_POP_WAIT: state_q <= S_ROW_WAIT;
				S_ROW_WAIT: state_q <= S_SCAN;
				S_SCAN: begin
					if (status.pending_empty) state_q <= S_POP;
				end
				S_FINISH: begin
					if (cmd.out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/grdfs_dp.sv
// grdfs_dp: datapath with adjacency rows, visited marks, walk stack and result registers
// depends on grdfs_pkg and grdfs_ram; controlled by grdfs_ctrl through dp_cmd_t

module grdfs_dp
	import grdfs_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic [KIND_W-1:0] kind,
	input  logic [VTX_W-1:0]  src_vertex,
	input  logic [VTX_W-1:0]  dst_vertex,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	output logic              edge_present,
	output logic [CNT_W-1:0]  reach_count,
	output logic              bad_vertex
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int KW = (CW > CNT_W) ? CW : CNT_W;
	localparam int XW = (VW > VTX_W) ? VW : VTX_W;
	localparam logic [MAX_VERTICES-1:0] BIT0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
	localparam logic [CW-1:0] DEPTH_MAX = CW'(MAX_VERTICES);

	logic [CNT_W-1:0]        vcount_q;
	kind_t                   kind_q;
	logic [VTX_W-1:0]        src_q, dst_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] pending_q;
	logic [CW-1:0]           sp_q;
	logic [CW-1:0]           count_q;
	logic                    present_q;
	logic                    rowv_s1;
	logic                    edge_present_q;
	logic [CNT_W-1:0]        reach_q;
	logic                    bad_q;

	logic [KW-1:0]           n_k, src_k, dst_k;
	logic [XW-1:0]           src_x, dst_x;
	logic [VW-1:0]           src_idx, dst_idx;
	logic                    bad;
	logic [MAX_VERTICES-1:0] live_mask;
	logic [MAX_VERTICES-1:0] row;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic [MAX_VERTICES-1:0] lowbit;
	logic [VW-1:0]           low_idx;
	logic [VW-1:0]           adj_raddr;
	logic [VW-1:0]           stk_rdata;
	logic [VW-1:0]           stk_waddr;
	logic [VW-1:0]           stk_wdata;
	logic                    stk_we;
	logic                    adj_re;
	logic                    push_ok;
	logic [CW-1:0]           sp_m1;

	// effective vertex count saturates at the array size
	assign n_k   = (KW'(vcount_q) > KW'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : KW'(vcount_q);
	assign src_k = KW'(src_q);
	assign dst_k = KW'(dst_q);
	assign src_x = XW'(src_q);
	assign dst_x = XW'(dst_q);
	assign src_idx = src_x[VW-1:0];
	assign dst_idx = dst_x[VW-1:0];

	always_comb begin
		case (kind_q)
			KIND_WALK:  bad = (src_k >= n_k);
			KIND_CLEAR: bad = 1'b0;
			default:    bad = (src_k >= n_k) || (dst_k >= n_k);
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			live_mask[i] = (KW'(i) < n_k);
		end
	end

	// never-written rows read as empty
	assign row = rowv_s1 ? adj_rdata : '0;

	// isolate the lowest pending successor
	assign lowbit = pending_q & (~pending_q + BIT0);

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (lowbit[i]) low_idx = low_idx | VW'(i);
		end
	end

	assign adj_re    = cmd.adj_rd_src || cmd.adj_rd_stk;
	assign adj_raddr = cmd.adj_rd_stk ? stk_rdata : src_idx;

	assign sp_m1     = sp_q - CW'(1);
	assign push_ok   = cmd.push_next && (sp_q < DEPTH_MAX);
	assign stk_we    = cmd.push_start || push_ok;
	assign stk_waddr = cmd.push_start ? '0 : sp_q[VW-1:0];
	assign stk_wdata = cmd.push_start ? src_idx : low_idx;

	grdfs_ram #(
		.WIDTH (MAX_VERTICES),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (cmd.adj_wr),
		.waddr (src_idx),
		.wdata (row | (BIT0 << dst_idx)),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	grdfs_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_VERTICES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (cmd.stk_pop),
		.raddr (sp_m1[VW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCOUNT_RESET;
			visited_q   <= '0;
			row_valid_q <= '0;
			sp_q        <= '0;
		end else begin
			if (cfg_we) vcount_q <= cfg_wdata;

			if (cmd.clear_marks) begin
				visited_q <= '0;
			end else if (cmd.mark_start) begin
				visited_q[src_idx] <= 1'b1;
			end else if (cmd.push_next) begin
				visited_q <= visited_q | lowbit;
			end

			if (cmd.adj_wr) row_valid_q[src_idx] <= 1'b1;

			if (cmd.push_start) begin
				sp_q <= CW'(1);
			end else if (cmd.stk_pop) begin
				sp_q <= sp_m1;
			end else if (push_ok) begin
				sp_q <= sp_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			kind_q    <= kind_t'(kind);
			src_q     <= src_vertex;
			dst_q     <= dst_vertex;
			present_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (cmd.query_cap) present_q <= row[dst_idx];
			if (cmd.mark_start) begin
				count_q <= visited_q[src_idx] ? '0 : CW'(1);
			end else if (cmd.push_next) begin
				count_q <= count_q + CW'(1);
			end
		end

		if (adj_re) rowv_s1 <= row_valid_q[adj_raddr];

		if (cmd.load_row) begin
			pending_q <= row & ~visited_q & live_mask;
		end else if (cmd.push_next) begin
			pending_q <= pending_q & ~lowbit;
		end

		if (cmd.out_load) begin
			edge_present_q <= present_q;
			reach_q        <= CNT_W'(count_q);
			bad_q          <= bad;
		end
	end

	assign status.kind          = kind_q;
	assign status.bad           = bad;
	assign status.stack_empty   = (sp_q == '0);
	assign status.pending_empty = (pending_q == '0);

	assign edge_present = edge_present_q;
	assign reach_count  = reach_q;
	assign bad_vertex   = bad_q;

`ifndef NO_ASSERTIONS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= DEPTH_MAX)
		else $error("walk stack pointer beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stk_pop |-> (sp_q != '0))
		else $error("pop from empty walk stack");

	a_push_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_next |-> ((lowbit != '0) && ((lowbit & ~live_mask) == '0)
			&& ((lowbit & visited_q) == '0)))
		else $error("pushed vertex is not a live unvisited successor");

	a_push_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_next |=> visited_q[$past(low_idx)])
		else $error("pushed vertex not marked visited");
`endif

endmodule

### sv/graph_reachability_dfs_top.sv
// graph_reachability_dfs_top: directed-graph engine with edge add/query and depth-first walk
// depends on grdfs_pkg, grdfs_ctrl, grdfs_dp and grdfs_ram
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_stall  | kind, src_vertex, dst_vertex
//   output   | out_valid / out_stall| edge_present, reach_count, bad_vertex
//   config   | cfg_we               | cfg_wdata (vertex_count)
//
// one item at a time, the next one accepted in the cycle after the previous result is loaded
// add and query read the source row in decode, then write it or capture the edge bit, then
// load the result; clear and a bad vertex go from decode straight to the result load; a walk
// repeats a stack check, a stack read, a row read and a scan that pushes each pending successor
// reset clears edges through per-row valid bits and clears visited marks; no clearing pass
// a result held by out_stall keeps the next item waiting at its end, not at its start

module graph_reachability_dfs_top
	import grdfs_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [VTX_W-1:0]  src_vertex,
	input  logic [VTX_W-1:0]  dst_vertex,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              edge_present,
	output logic [CNT_W-1:0]  reach_count,
	output logic              bad_vertex
);

	dp_cmd_t    cmd;
	dp_status_t status;

	grdfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	grdfs_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.kind         (kind),
		.src_vertex   (src_vertex),
		.dst_vertex   (dst_vertex),
		.cmd          (cmd),
		.status       (status),
		.edge_present (edge_present),
		.reach_count  (reach_count),
		.bad_vertex   (bad_vertex)
	);

endmodule
